// ===== design/lcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfs_pkg: shared definitions of the lighting cue fade sequencer
// Field widths, table geometry, configuration layout and the job record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package lcfs_pkg;

  // Cue table geometry.
  localparam int MAX_CUES  = 64;
  localparam int IDX_W     = $clog2(MAX_CUES);
  localparam int CUE_IDX_W = 7;

  // Field widths.
  localparam int LEVEL_W   = 7;
  localparam int TIME_W    = 16;
  localparam int SLOT_W    = 6;
  localparam int DELAY_W   = 8;
  localparam int DUR_W     = 8;
  localparam int BITS_W    = 5;
  localparam int ENTRY_W   = LEVEL_W + TIME_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Fade delay arithmetic.
  localparam int DUR_SCALE = 100000;
  localparam int NUM_W     = 25;                    // DUR_SCALE * 255 fits
  localparam int DEN_W     = LEVEL_W + 31;          // change << up to 31
  localparam int DIV_W     = DEN_W + DELAY_W + 1;   // divisor shifted for the top step
  localparam int STEP_W    = $clog2(DELAY_W + 1);
  localparam int DLY_IDX_W = $clog2(DELAY_W);
  localparam logic [DELAY_W-1:0] DELAY_SAT = '1;

  // Job queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUE_COUNT     = 2'd0,
    CFG_RESTART_LEVEL = 2'd1,
    CFG_RESTART_DELAY = 2'd2,
    CFG_DIMMER_BITS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CUE_IDX_W-1:0] cue_count;
    logic [LEVEL_W-1:0]   restart_level;
    logic [DELAY_W-1:0]   restart_delay;
    logic [BITS_W-1:0]    dimmer_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cue_count:     7'd27,
    restart_level: 7'd1,
    restart_delay: 8'd1,
    dimmer_bits:   5'd13
  };

  // One classified tick: what the back end has to emit.
  typedef struct packed {
    logic               has_cue;
    logic               has_rst;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] change;
    logic [DUR_W-1:0]   dur;
  } job_t;

endpackage

// ===== design/lcfs_item_if.sv =====
// ----------------------------------------------------------------------------
// lcfs_item_if: input channel of the cue sequencer
// Valid/ready handshake carrying one tick or one table load.
// ----------------------------------------------------------------------------
interface lcfs_item_if;
  import lcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic               cue_pin;
  logic               start_pin;
  logic [SLOT_W-1:0]  entry_index;
  logic [LEVEL_W-1:0] entry_level;
  logic [TIME_W-1:0]  entry_time;

  modport source (
    output valid, operation, cue_pin, start_pin, entry_index, entry_level, entry_time,
    input  ready
  );

  modport sink (
    input  valid, operation, cue_pin, start_pin, entry_index, entry_level, entry_time,
    output ready
  );
endinterface

// ===== design/lcfs_result_if.sv =====
// ----------------------------------------------------------------------------
// lcfs_result_if: result channel of the cue sequencer
// Valid/ready handshake carrying one cue or restart message.
// ----------------------------------------------------------------------------
interface lcfs_result_if;
  import lcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [DELAY_W-1:0] step_delay;
  logic               is_restart;
  logic               last;

  modport source (
    output valid, level, step_delay, is_restart, last,
    input  ready
  );

  modport sink (
    input  valid, level, step_delay, is_restart, last,
    output ready
  );
endinterface

// ===== design/lcfs_front.sv =====
// ----------------------------------------------------------------------------
// lcfs_front: transaction intake and cue classification
// Writes table loads, tracks the cue pin and index, reads both neighboring
// table entries and hands a classified job to the queue.
// ----------------------------------------------------------------------------
module lcfs_front (
  input  logic           clk,
  input  logic           rst,
  input  lcfs_pkg::cfg_t cfg,
  lcfs_item_if.sink      item,
  output logic           push,
  output lcfs_pkg::job_t push_job,
  input  logic           q_full
);
  import lcfs_pkg::*;

  logic [ENTRY_W-1:0]   table_mem [MAX_CUES];
  logic [ENTRY_W-1:0]   rd_cur;
  logic [ENTRY_W-1:0]   rd_prv;
  logic [CUE_IDX_W-1:0] cue_index;
  logic [CUE_IDX_W-1:0] idx_adv;
  logic [CUE_IDX_W-1:0] idx_prv;
  logic                 prev_pin;
  logic                 pend_valid;
  logic                 pend_cue;
  logic                 pend_rst;
  logic                 accept;
  logic                 is_load;
  logic                 is_tick;
  logic                 advance;
  logic                 has_cue;
  logic                 has_rst;
  logic                 slot_ok;
  logic [LEVEL_W-1:0]   lvl_cur;
  logic [LEVEL_W-1:0]   lvl_prv;
  logic [TIME_W-1:0]    time_diff;

  assign item.ready = !pend_valid || !q_full;
  assign accept     = item.valid && item.ready;
  assign is_load    = accept && (item.operation == OP_LOAD);
  assign is_tick    = accept && (item.operation == OP_TICK);
  assign slot_ok    = 32'(item.entry_index) < MAX_CUES;

  assign advance = item.cue_pin != prev_pin;
  assign idx_adv = advance ? cue_index + CUE_IDX_W'(1) : cue_index;
  assign idx_prv = idx_adv - CUE_IDX_W'(1);
  assign has_cue = advance && (idx_adv != '0) && (idx_adv < cfg.cue_count)
                   && (32'(idx_adv) < MAX_CUES);
  assign has_rst = (idx_adv >= cfg.cue_count) || item.start_pin;

  // Both tables share one memory; a tick reads the new cue and its predecessor.
  always_ff @(posedge clk) begin
    if (is_load && slot_ok) begin
      table_mem[IDX_W'(item.entry_index)] <= {item.entry_level, item.entry_time};
    end
    if (is_tick) begin
      rd_cur <= table_mem[IDX_W'(idx_adv)];
      rd_prv <= table_mem[IDX_W'(idx_prv)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cue_index  <= '0;
      prev_pin   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (is_tick) begin
        cue_index  <= has_rst ? '0 : idx_adv;
        prev_pin   <= item.cue_pin;
        pend_valid <= has_cue || has_rst;
        pend_cue   <= has_cue;
        pend_rst   <= has_rst;
      end else if (push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  assign lvl_cur   = rd_cur[ENTRY_W-1:TIME_W];
  assign lvl_prv   = rd_prv[ENTRY_W-1:TIME_W];
  assign time_diff = rd_cur[TIME_W-1:0] - rd_prv[TIME_W-1:0];

  assign push            = pend_valid && !q_full;
  assign push_job.has_cue = pend_cue;
  assign push_job.has_rst = pend_rst;
  assign push_job.level   = lvl_cur;
  assign push_job.change  = (lvl_cur >= lvl_prv) ? lvl_cur - lvl_prv : lvl_prv - lvl_cur;
  assign push_job.dur     = time_diff[DUR_W-1:0];

endmodule

// ===== design/lcfs_queue.sv =====
// ----------------------------------------------------------------------------
// lcfs_queue: job queue between front and back end
// A small first-in first-out buffer of classified ticks.
// ----------------------------------------------------------------------------
module lcfs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcfs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output lcfs_pkg::job_t pop_job,
  output logic           empty
);
  import lcfs_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/lcfs_back.sv =====
// ----------------------------------------------------------------------------
// lcfs_back: fade delay computation and message output
// Takes jobs from the queue, divides out the rounded step delay one quotient
// bit per cycle and emits the cue and restart messages.
// ----------------------------------------------------------------------------
module lcfs_back (
  input  logic           clk,
  input  logic           rst,
  input  lcfs_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  lcfs_pkg::job_t q_job,
  output logic           pop,
  lcfs_result_if.source  result
);
  import lcfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_CUE,
    S_RST
  } state_t;

  state_t             state;
  job_t               job;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dsh;
  logic [STEP_W-1:0]  step;
  logic [DELAY_W-1:0] delay;
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [DELAY_W-1:0] out_delay;
  logic               out_restart;
  logic               out_last;
  logic               out_free;
  logic               out_load;
  logic               fits;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || result.ready;
  assign out_load = out_free && ((state == S_CUE) || (state == S_RST));
  assign fits     = rem >= dsh;

  assign result.valid      = out_valid;
  assign result.level      = out_level;
  assign result.step_delay = out_delay;
  assign result.is_restart = out_restart;
  assign result.last       = out_last;

  // Delay = floor((2*num + den) / (2*den)), saturated. The first step tests
  // the divisor shifted past the delay width, which means saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            delay <= DELAY_SAT;
            if (q_job.has_cue && (q_job.change != '0)) begin
              state <= S_MUL;
            end else if (q_job.has_cue) begin
              state <= S_CUE;
            end else begin
              state <= S_RST;
            end
          end
        end
        S_MUL: begin
          num   <= NUM_W'(DUR_SCALE) * NUM_W'(job.dur);
          den   <= DEN_W'(job.change) << cfg.dimmer_bits;
          state <= S_PREP;
        end
        S_PREP: begin
          rem   <= DIV_W'({num, 1'b0}) + DIV_W'(den);
          dsh   <= DIV_W'(den) << (DELAY_W + 1);
          step  <= STEP_W'(DELAY_W);
          delay <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rem <= rem - dsh;
          end
          dsh  <= dsh >> 1;
          step <= step - STEP_W'(1);
          if (step == STEP_W'(DELAY_W)) begin
            if (fits) begin
              delay <= DELAY_SAT;
              state <= S_CUE;
            end
          end else begin
            if (fits) begin
              delay[step[DLY_IDX_W-1:0]] <= 1'b1;
            end
            if (step == '0) begin
              state <= S_CUE;
            end
          end
        end
        S_CUE: begin
          if (out_free) begin
            out_level   <= job.level;
            out_delay   <= delay;
            out_restart <= 1'b0;
            out_last    <= !job.has_rst;
            state       <= job.has_rst ? S_RST : S_IDLE;
          end
        end
        S_RST: begin
          if (out_free) begin
            out_level   <= cfg.restart_level;
            out_delay   <= cfg.restart_delay;
            out_restart <= 1'b1;
            out_last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lighting_cue_fade_sequencer.sv =====
// ----------------------------------------------------------------------------
// lighting_cue_fade_sequencer: cue table player with fade step delays
// Plays a loaded table of cue levels and time stamps, advancing on every
// change of the cue pin and restarting at the end of the table or on start.
//
//   Channel  Dir  Handshake            Carries
//   item     in   valid/ready          operation, pins, one table entry
//   result   out  valid/ready          level, step_delay, is_restart, last
//   cfg      in   cfg_write (no wait)  cfg_index, cfg_data
//
// A load transaction writes the cue table and gives no message. A tick whose
// cue message needs a division passes the front-end table read, the job
// queue and the back-end multiply, prepare and divide states, the divider
// producing one quotient bit per cycle over at most nine steps. A restart
// alone, or a cue with no level change, skips the multiply, prepare and
// divide states; a restart that follows a cue comes after the cue message.
// The front end accepts a new transaction every cycle while the job queue
// has room. Reset is synchronous and clears the settings, the index, the pin
// history, the queue and the output; the cue table keeps its contents. A
// stalled result holds the back end but not the front end until the queue
// fills.
// ----------------------------------------------------------------------------
module lighting_cue_fade_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  lcfs_item_if.sink                         item,
  lcfs_result_if.source                     result,
  input  logic                              cfg_write,
  input  logic [lcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lcfs_pkg::*;

  cfg_t cfg;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  // Configuration registers. The index is two bits wide, so every code names
  // one of the four registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CUE_COUNT:     cfg.cue_count     <= CUE_IDX_W'(cfg_data);
        CFG_RESTART_LEVEL: cfg.restart_level <= LEVEL_W'(cfg_data);
        CFG_RESTART_DELAY: cfg.restart_delay <= DELAY_W'(cfg_data);
        CFG_DIMMER_BITS:   cfg.dimmer_bits   <= BITS_W'(cfg_data);
      endcase
    end
  end

  // The front end classifies each tick: whether it produces a cue message,
  // a restart message or both, along with the table data the delay needs.
  lcfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // The queue lets intake run ahead while the divider is busy or the
  // result side is stalled.
  lcfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // The back end works out the rounded step delay and drives the output
  // register, which frees the back end while a result waits to be taken.
  lcfs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== design/lcfs_checker.sv =====
// ----------------------------------------------------------------------------
// lcfs_checker: port-level checks of the cue sequencer
// Watches the result channel for stalled results, the state after reset and
// the ordering of messages within one tick.
module lcfs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             r_valid,
  input logic                             r_ready,
  input logic [lcfs_pkg::LEVEL_W-1:0]     r_level,
  input logic [lcfs_pkg::DELAY_W-1:0]     r_delay,
  input logic                             r_restart,
  input logic                             r_last
);
  import lcfs_pkg::*;

  // A stalled result stays offered unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable({r_level, r_delay, r_restart, r_last}))
    else $error("result changed while stalled");

  // Reset leaves no result on offer.
  a_reset: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid right after reset");

  // A restart message always closes the tick's results.
  a_rst_last: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_restart |-> r_last)
    else $error("restart message not marked last");

  // A cue message that is not last is followed at once by the restart.
  a_cue_then_rst: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_ready && !r_last |=> r_valid && r_restart)
    else $error("missing restart after a non-final cue message");

endmodule

bind lighting_cue_fade_sequencer lcfs_checker u_lcfs_checker (
  .clk       (clk),
  .rst       (rst),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .r_level   (result.level),
  .r_delay   (result.step_delay),
  .r_restart (result.is_restart),
  .r_last    (result.last)
);

// ===== bench/lighting_cue_fade_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// lighting_cue_fade_sequencer_tb: self-checking bench of the cue sequencer
// Fills the cue table, walks a short table of directed transactions, then
// runs randomized phases under several settings and handshake idling
// patterns. Every result transaction is checked against a predictor kept
// inside the bench or against a value typed into the directed table.
// ----------------------------------------------------------------------------
module lighting_cue_fade_sequencer_tb;
  import lcfs_pkg::*;

  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 160;
  localparam int SETTLE_CYCLES  = 40;    // covers a tick in flight with no message
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the job queue
  localparam int QUIET_LIMIT    = 5000;  // cycles with no transaction before giving up
  localparam int DIRECTED_COUNT = 16;

  // How a directed row is checked: by the predictor, by a value typed in, or with no message expected.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } check_t;

  typedef struct packed {
    op_t                operation;
    logic               cue_pin;
    logic               start_pin;
    logic [SLOT_W-1:0]  entry_index;
    logic [LEVEL_W-1:0] entry_level;
    logic [TIME_W-1:0]  entry_time;
  } cue_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DELAY_W-1:0] step_delay;
    logic               is_restart;
    logic               last;
  } fade_msg_t;

  typedef struct packed {
    cue_item_t stim;
    check_t    chk;
    fade_msg_t typed;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcfs_item_if   item_ch ();
  lcfs_result_if result_ch ();

  lighting_cue_fade_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: settings, cue position, pin history and the cue table.
  cfg_t               model_cfg;
  logic [6:0]         cue_pos;
  logic               last_pin;
  logic [LEVEL_W-1:0] level_tbl [MAX_CUES];
  logic [TIME_W-1:0]  time_tbl  [MAX_CUES];

  fade_msg_t step_msgs [$];   // messages caused by the transaction just accepted
  fade_msg_t pending   [$];   // messages still owed by the block, oldest first

  int  send_gap_pct;
  int  stall_pct;
  bit  hold_req;
  int  mismatch_count;

  // Directed rows. The cue table is first filled with random content, so the
  // table reads below only ever touch written slots. Rows typed in by hand are
  // the ones whose answer is obvious: quiet ticks, restarts with the reset
  // settings, a cue with no level change, and a cue with zero duration.
  row_t directed_rows [DIRECTED_COUNT] = '{
    // Quiet tick right after reset: no change, no start.
    '{'{OP_TICK, 1'b0, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_NONE,  '0},
    // Start pin alone gives a restart with the reset level and delay.
    '{'{OP_TICK, 1'b0, 1'b1, 6'd0,  7'd0,   16'd0},     CHK_ONE,   '{7'd1, 8'd1, 1'b1, 1'b1}},
    '{'{OP_LOAD, 1'b1, 1'b1, 6'd0,  7'd0,   16'd0},     CHK_NONE,  '0},
    '{'{OP_LOAD, 1'b0, 1'b0, 6'd1,  7'd100, 16'd255},   CHK_NONE,  '0},
    '{'{OP_LOAD, 1'b1, 1'b0, 6'd2,  7'd100, 16'd300},   CHK_NONE,  '0},
    '{'{OP_LOAD, 1'b0, 1'b1, 6'd3,  7'd0,   16'hFFFF},  CHK_NONE,  '0},
    '{'{OP_LOAD, 1'b1, 1'b1, 6'd4,  7'd100, 16'hFFFF},  CHK_NONE,  '0},
    '{'{OP_LOAD, 1'b0, 1'b0, 6'd63, 7'd100, 16'hFFFF},  CHK_NONE,  '0},
    // Rising cue pin: full swing over the largest duration.
    '{'{OP_TICK, 1'b1, 1'b0, 6'd63, 7'd127, 16'hFFFF},  CHK_MODEL, '0},
    // Pin held: nothing happens.
    '{'{OP_TICK, 1'b1, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_NONE,  '0},
    // Falling pin into a slot with the same level: delay saturates.
    '{'{OP_TICK, 1'b0, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_ONE,   '{7'd100, 8'd255, 1'b0, 1'b1}},
    // Full swing down, duration wrapped modulo 256.
    '{'{OP_TICK, 1'b1, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_MODEL, '0},
    // Same time stamp on both slots: zero duration gives a zero delay.
    '{'{OP_TICK, 1'b0, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_ONE,   '{7'd100, 8'd0, 1'b0, 1'b1}},
    // Cue and start together: a cue message followed by a restart.
    '{'{OP_TICK, 1'b1, 1'b1, 6'd0,  7'd0,   16'd0},     CHK_MODEL, '0},
    // Start with no pin change: restart only.
    '{'{OP_TICK, 1'b1, 1'b1, 6'd0,  7'd0,   16'd0},     CHK_ONE,   '{7'd1, 8'd1, 1'b1, 1'b1}},
    // First cue again after the restart.
    '{'{OP_TICK, 1'b0, 1'b0, 6'd0,  7'd0,   16'd0},     CHK_MODEL, '0}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fade step delay: round(100000 * dur / (chg << bits)), halves away from
  // zero, saturating at 255. No level change means the slowest fade.
  function automatic logic [DELAY_W-1:0] fade_step(logic [DUR_W-1:0] dur,
                                                   logic [LEVEL_W-1:0] chg,
                                                   logic [BITS_W-1:0] bits);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    if (chg == '0) return DELAY_SAT;
    num = 64'd100000 * 64'(dur);
    den = 64'(chg) << bits;
    quo = (2 * num + den) / (2 * den);
    return (quo > 64'd255) ? DELAY_SAT : quo[DELAY_W-1:0];
  endfunction

  // Predictor: advances the bench copy of the block by one accepted
  // transaction and leaves the messages it causes in step_msgs.
  function automatic void advance_cues(cue_item_t it);
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] prv;
    logic [LEVEL_W-1:0] chg;
    logic [DUR_W-1:0]   dur;
    logic [SLOT_W-1:0]  slot;
    logic               has_cue;
    logic               has_rst;
    fade_msg_t          cue_msg;
    step_msgs.delete();
    if (it.operation == OP_LOAD) begin
      // The pins are not sampled by a table load.
      level_tbl[it.entry_index] = it.entry_level;
      time_tbl[it.entry_index]  = it.entry_time;
      return;
    end
    has_cue = 1'b0;
    cue_msg = '0;
    if (it.cue_pin != last_pin) begin
      cue_pos = cue_pos + 7'd1;
      // A cue message goes out only for an index inside the played table.
      if (cue_pos >= 7'd1 && cue_pos < model_cfg.cue_count && cue_pos < 7'(MAX_CUES)) begin
        slot = cue_pos[SLOT_W-1:0];
        cur  = level_tbl[slot];
        prv  = level_tbl[slot - 6'd1];
        dur  = time_tbl[slot][DUR_W-1:0] - time_tbl[slot - 6'd1][DUR_W-1:0];
        chg  = (cur >= prv) ? cur - prv : prv - cur;
        has_cue = 1'b1;
        cue_msg = '{cur, fade_step(dur, chg, model_cfg.dimmer_bits), 1'b0, 1'b0};
      end
    end
    // The end of the table is checked after the cue step, so a lowered
    // cue count or a start request restarts on this same tick.
    has_rst = (cue_pos >= model_cfg.cue_count) || it.start_pin;
    if (has_cue) begin
      cue_msg.last = !has_rst;
      step_msgs.push_back(cue_msg);
    end
    if (has_rst) begin
      cue_pos = '0;
      step_msgs.push_back('{model_cfg.restart_level, model_cfg.restart_delay, 1'b1, 1'b1});
    end
    last_pin = it.cue_pin;
  endfunction

  // Offers one input transaction, idling first at the sender's rate. valid
  // stays high from one accepted transaction to the next unless a gap falls
  // between them, so it is never lowered and raised within one time step.
  task automatic send_item(cue_item_t it, check_t chk, fade_msg_t typed);
    while ($urandom_range(99) < send_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= it.operation;
    item_ch.cue_pin     <= it.cue_pin;
    item_ch.start_pin   <= it.start_pin;
    item_ch.entry_index <= it.entry_index;
    item_ch.entry_level <= it.entry_level;
    item_ch.entry_time  <= it.entry_time;
    do @(posedge clk); while (!item_ch.ready);
    // Accepted at this edge: the predictor always advances, and a typed row
    // replaces the predicted messages with the value written in the table.
    advance_cues(it);
    case (chk)
      CHK_MODEL: foreach (step_msgs[k]) pending.push_back(step_msgs[k]);
      CHK_ONE:   pending.push_back(typed);
      default:   ;
    endcase
  endtask

  // Writes all four settings, one per cycle, while the block is idle.
  task automatic apply_settings(logic [7:0] count, logic [7:0] rlevel,
                                logic [7:0] rdelay, logic [7:0] bits);
    cfg_reg_t   sel;
    logic [7:0] value;
    for (int r = 0; r < 4; r++) begin
      sel = cfg_reg_t'(r);
      case (sel)
        CFG_CUE_COUNT:     value = count;
        CFG_RESTART_LEVEL: value = rlevel;
        CFG_RESTART_DELAY: value = rdelay;
        default:           value = bits;
      endcase
      cfg_write <= 1'b1;
      cfg_index <= sel;
      cfg_data  <= value;
      @(posedge clk);
      case (sel)
        CFG_CUE_COUNT:     model_cfg.cue_count     = value[CUE_IDX_W-1:0];
        CFG_RESTART_LEVEL: model_cfg.restart_level = value[LEVEL_W-1:0];
        CFG_RESTART_DELAY: model_cfg.restart_delay = value[DELAY_W-1:0];
        default:           model_cfg.dimmer_bits   = value[BITS_W-1:0];
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // Stops offering, waits for every owed message, then lets a tick that
  // causes no message drain out of the block.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random transaction. Most are ticks that flip the cue pin, which walks the
  // index through the table and into restarts; the rest are held pins, start
  // requests and table reloads. Unused fields carry random noise.
  function automatic cue_item_t random_item();
    cue_item_t it;
    it.entry_index = SLOT_W'($urandom_range(MAX_CUES - 1));
    it.entry_level = LEVEL_W'($urandom_range(100));
    it.entry_time  = TIME_W'($urandom_range(16'hFFFF));
    it.start_pin   = ($urandom_range(99) < 4);
    if ($urandom_range(99) < 15) begin
      it.operation = OP_LOAD;
      it.cue_pin   = 1'($urandom_range(1));
      it.start_pin = 1'($urandom_range(1));
    end else begin
      it.operation = OP_TICK;
      it.cue_pin   = ($urandom_range(99) < 75) ? !last_pin : last_pin;
    end
    return it;
  endfunction

  // Receiver: stalls at the phase's rate, and once holds off for a long
  // stretch so the job queue fills and the input side stalls too.
  initial begin : receiver
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker: each accepted message against the oldest expectation.
  always @(posedge clk) begin
    fade_msg_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected message: level %0d step_delay %0d is_restart %0d last %0d",
               result_ch.level, result_ch.step_delay, result_ch.is_restart, result_ch.last);
        mismatch_count++;
      end else begin
        want = pending.pop_front();
        if (result_ch.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, result_ch.level);
          mismatch_count++;
        end
        if (result_ch.step_delay !== want.step_delay) begin
          $error("step_delay: expected %0d, got %0d", want.step_delay, result_ch.step_delay);
          mismatch_count++;
        end
        if (result_ch.is_restart !== want.is_restart) begin
          $error("is_restart: expected %0d, got %0d", want.is_restart, result_ch.is_restart);
          mismatch_count++;
        end
        if (result_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // too long. The long hold-off and the settle pauses stay well below it.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    cue_item_t it;
    int        mode;

    // Every input known from time zero, with reset held at the start.
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= CFG_CUE_COUNT;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= OP_TICK;
    item_ch.cue_pin     <= 1'b0;
    item_ch.start_pin   <= 1'b0;
    item_ch.entry_index <= '0;
    item_ch.entry_level <= '0;
    item_ch.entry_time  <= '0;
    model_cfg      = CFG_RESET;
    cue_pos        = '0;
    last_pin       = 1'b0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every slot first, so that no tick can read an unwritten entry.
    for (int s = 0; s < MAX_CUES; s++) begin
      it             = random_item();
      it.operation   = OP_LOAD;
      it.entry_index = SLOT_W'(s);
      send_item(it, CHK_MODEL, '0);
    end

    // Directed table under the reset settings, with light idling on both sides.
    send_gap_pct = 36;
    stall_pct    = 36;
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].stim, directed_rows[r].chk, directed_rows[r].typed);
    end
    wait_idle();

    // Random phases. The first two use the extremes of every setting; the
    // index carries over between phases, so a lowered cue count also leaves
    // the index beyond the table and forces an immediate restart.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       apply_settings(8'd64, 8'd100, 8'd255, 8'd8);
        1:       apply_settings(8'd1, 8'd0, 8'd0, 8'd16);
        2:       apply_settings(8'd3, 8'd55, 8'd17, 8'd10);
        default: apply_settings(8'($urandom_range(1, 64)), 8'($urandom_range(100)),
                                8'($urandom_range(255)), 8'($urandom_range(8, 16)));
      endcase
      // Idling pattern: none, sender gaps, receiver stalls, then both.
      mode = phase % 4;
      send_gap_pct = (mode == 1) ? 48 : (mode == 3) ? 36 : 0;
      stall_pct    = (mode == 2) ? 48 : (mode == 3) ? 36 : 0;
      if (phase == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item(), CHK_MODEL, '0);
      wait_idle();
    end

    if (mismatch_count == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
